@@ rtl/iems_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iems_pkg
// Shared types and constants for the extreme pixel statistics block.
// ----------------------------------------------------------------------------
package iems_pkg;

	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned SUM_W    = 10;
	localparam int unsigned COORD_W  = 12;
	localparam int unsigned WIDTH_W  = 13;
	localparam int unsigned POS_W    = 2 * COORD_W;
	localparam int unsigned COLOUR_W = 3 * CHAN_W;

	localparam logic [WIDTH_W-1:0] MAX_WIDTH   = WIDTH_W'(4096);
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(4096);
	localparam logic [COORD_W-1:0] ROW_LAST    = COORD_W'(4095);

	// report kinds, in output order
	localparam logic [2:0] KIND_MAX_PIX = 3'd0;
	localparam logic [2:0] KIND_MIN_PIX = 3'd1;
	localparam logic [2:0] KIND_MAX_R   = 3'd2;
	localparam logic [2:0] KIND_MIN_B   = 3'd7;

	// tracker slots
	localparam int unsigned SLOT_MAX = 0;
	localparam int unsigned SLOT_MIN = 1;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              end_of_frame;
	} pixel_t;

	typedef struct packed {
		logic [2:0]         report_kind;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [CHAN_W-1:0]  pix_red;
		logic [CHAN_W-1:0]  pix_green;
		logic [CHAN_W-1:0]  pix_blue;
		logic [SUM_W-1:0]   extreme_value;
		logic               last_report;
	} report_t;

	// one frame's trackers: colour has red in the low byte, position has y on top
	typedef struct packed {
		logic [1:0][SUM_W-1:0]    sum_val;
		logic [1:0][COLOUR_W-1:0] sum_col;
		logic [5:0][CHAN_W-1:0]   chan_val;
		logic [7:0][POS_W-1:0]    pos;
	} frame_stats_t;

endpackage : iems_pkg
`default_nettype wire

@@ rtl/iems_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iems_front
// Raster position tracking and per-pixel tracker updates; hands the finished
// trackers of a frame to the queue on the end-of-frame beat.
// ----------------------------------------------------------------------------
module iems_front
	import iems_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [WIDTH_W-1:0] cfg_data,
	input  wire logic               pix_take,
	input  wire pixel_t             pix,
	output      logic               push,
	output      frame_stats_t       push_data
);

	logic [WIDTH_W-1:0] width_q;
	logic [WIDTH_W-1:0] width_eff;
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic               started_q;
	frame_stats_t       stats_q;
	frame_stats_t       stats_nxt;
	logic [SUM_W-1:0]   sum;
	logic [POS_W-1:0]   pos;
	logic [2:0][CHAN_W-1:0] ch;
	logic               seed;
	logic               wrap;

	always_comb begin
		if (width_q == '0) begin
			width_eff = WIDTH_W'(1);
		end else if (width_q > MAX_WIDTH) begin
			width_eff = MAX_WIDTH;
		end else begin
			width_eff = width_q;
		end
		wrap = ({1'b0, col_q} + WIDTH_W'(1)) >= width_eff;
	end

	always_comb begin
		ch[0] = pix.red;
		ch[1] = pix.green;
		ch[2] = pix.blue;
		sum   = SUM_W'(pix.red) + SUM_W'(pix.green) + SUM_W'(pix.blue);
		pos   = {row_q, col_q};
		seed  = !started_q;

		stats_nxt = stats_q;
		if (seed || sum > stats_q.sum_val[SLOT_MAX]) begin
			stats_nxt.sum_val[SLOT_MAX] = sum;
			stats_nxt.sum_col[SLOT_MAX] = {pix.blue, pix.green, pix.red};
			stats_nxt.pos[KIND_MAX_PIX] = pos;
		end
		if (seed || sum < stats_q.sum_val[SLOT_MIN]) begin
			stats_nxt.sum_val[SLOT_MIN] = sum;
			stats_nxt.sum_col[SLOT_MIN] = {pix.blue, pix.green, pix.red};
			stats_nxt.pos[KIND_MIN_PIX] = pos;
		end
		for (int k = 0; k < 3; k++) begin
			if (seed || ch[k] > stats_q.chan_val[k]) begin
				stats_nxt.chan_val[k] = ch[k];
				stats_nxt.pos[2 + k]  = pos;
			end
			if (seed || ch[k] < stats_q.chan_val[3 + k]) begin
				stats_nxt.chan_val[3 + k] = ch[k];
				stats_nxt.pos[5 + k]      = pos;
			end
		end
	end

	assign push      = pix_take && pix.end_of_frame;
	assign push_data = stats_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (cfg_we) begin
			width_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			started_q <= 1'b0;
			stats_q   <= '0;
		end else if (pix_take) begin
			if (pix.end_of_frame) begin
				col_q     <= '0;
				row_q     <= '0;
				started_q <= 1'b0;
				stats_q   <= '0;
			end else begin
				started_q <= 1'b1;
				stats_q   <= stats_nxt;
				if (wrap) begin
					col_q <= '0;
					// row count saturates on very tall frames
					if (row_q != ROW_LAST) begin
						row_q <= row_q + COORD_W'(1);
					end
				end else begin
					col_q <= col_q + COORD_W'(1);
				end
			end
		end
	end

endmodule : iems_front
`default_nettype wire

@@ rtl/iems_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iems_queue
// Two-entry queue of finished frame trackers between front and back.
// ----------------------------------------------------------------------------
module iems_queue
	import iems_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire frame_stats_t push_data,
	input  wire logic         pop,
	output      logic         full,
	output      logic         not_empty,
	output      frame_stats_t head
);

	frame_stats_t entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule : iems_queue
`default_nettype wire

@@ rtl/iems_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iems_back
// Walks the head frame of the queue through its eight reports into a
// registered output stage.
// ----------------------------------------------------------------------------
module iems_back
	import iems_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         not_empty,
	input  wire frame_stats_t head,
	output      logic         pop,
	output      logic         report_valid,
	input  wire logic         report_ready,
	output      report_t      report
);

	logic [2:0] kind_q;
	logic [2:0] chan_idx;
	logic       load;
	logic       out_valid_q;
	report_t    out_q;
	report_t    rep;

	always_comb begin
		rep             = '0;
		chan_idx        = kind_q - KIND_MAX_R;
		rep.report_kind = kind_q;
		rep.pos_x       = head.pos[kind_q][COORD_W-1:0];
		rep.pos_y       = head.pos[kind_q][POS_W-1:COORD_W];
		if (kind_q == KIND_MAX_PIX || kind_q == KIND_MIN_PIX) begin
			rep.pix_red       = head.sum_col[kind_q[0]][CHAN_W-1:0];
			rep.pix_green     = head.sum_col[kind_q[0]][2*CHAN_W-1:CHAN_W];
			rep.pix_blue      = head.sum_col[kind_q[0]][3*CHAN_W-1:2*CHAN_W];
			rep.extreme_value = head.sum_val[kind_q[0]];
		end else begin
			rep.extreme_value = SUM_W'(head.chan_val[chan_idx]);
		end
		rep.last_report = kind_q == KIND_MIN_B;
	end

	// output stage refills whenever it is empty or its beat is taken
	assign load         = !out_valid_q || report_ready;
	assign pop          = load && not_empty && (kind_q == KIND_MIN_B);
	assign report_valid = out_valid_q;
	assign report       = out_q;

	always_ff @(posedge clk) begin
		if (load && not_empty) begin
			out_q <= rep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= KIND_MAX_PIX;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= not_empty;
			if (not_empty) begin
				kind_q <= kind_q + 3'd1;
			end
		end
	end

endmodule : iems_back
`default_nettype wire

@@ rtl/image_extreme_pixel_stats.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// image_extreme_pixel_stats
// Brightest/darkest pixel and per-channel min/max with positions per frame.
// ----------------------------------------------------------------------------
// Pixels enter on the pixel channel (valid/ready), one beat per cycle, in
// raster order; the column wraps at the width set through the cfg channel
// (always ready, write only while idle). Every pixel updates the trackers in
// the cycle it is taken. The beat flagged end_of_frame closes the frame: its
// trackers go into a two-entry queue and the front starts a fresh frame on
// the next cycle, so pixels keep flowing at one per cycle.
// The back drains the queue as eight report beats (kind 0 to 7, last_report
// on kind 7), one per cycle while report_ready allows, through a registered
// output stage. The first report is valid once the frame's trackers have
// passed the queue entry and the output register. pixel_ready drops only
// while both queue entries are full, which happens when frames are shorter
// than eight pixels or the receiver stalls report_ready. A stalled report
// holds. Reset clears position, trackers, queue and output stage and sets
// the width to 4096.
// ----------------------------------------------------------------------------
module image_extreme_pixel_stats
	import iems_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output      logic               cfg_ready,
	input  wire logic [WIDTH_W-1:0] cfg_data,
	input  wire logic               pixel_valid,
	output      logic               pixel_ready,
	input  wire pixel_t             pixel,
	output      logic               report_valid,
	input  wire logic               report_ready,
	output      report_t            report
);

	logic         q_full;
	logic         q_not_empty;
	logic         push;
	logic         pop;
	frame_stats_t push_data;
	frame_stats_t head;

	assign cfg_ready   = 1'b1;
	assign pixel_ready = !q_full;

	iems_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.pix_take  (pixel_valid && pixel_ready),
		.pix       (pixel),
		.push      (push),
		.push_data (push_data)
	);

	iems_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	iems_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.not_empty    (q_not_empty),
		.head         (head),
		.pop          (pop),
		.report_valid (report_valid),
		.report_ready (report_ready),
		.report       (report)
	);

endmodule : image_extreme_pixel_stats
`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for image_extreme_pixel_stats. Pixels are streamed with
// random gaps while the report side stalls at random. A local model tracks the
// frame extremes and queues the eight reports each end-of-frame beat should
// produce. Every report beat is checked field by field against the oldest
// queued report. Directed frames cover single pixels, ties, colour extremes,
// odd widths and width changes inside a frame. A random phase then runs
// frames of random length.
// ----------------------------------------------------------------------------
module testbench;
	import iems_pkg::*;

	localparam int unsigned CHANNELS      = 3;
	localparam int unsigned KIND_COUNT    = 8;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned STUCK_LIMIT   = 2000;
	localparam int unsigned RANDOM_PIXELS = 300;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [WIDTH_W-1:0] cfg_data;
	logic               pixel_valid;
	logic               pixel_ready;
	pixel_t             pixel;
	logic               report_valid;
	logic               report_ready;
	report_t            report;

	int unsigned idle_pct     = 24;
	int unsigned mismatches   = 0;
	int unsigned stuck_cycles = 0;

	// local copy of the block's frame state
	logic [WIDTH_W-1:0] image_width;
	logic [COORD_W-1:0] column_now;
	logic [COORD_W-1:0] row_now;
	logic               frame_open;
	frame_stats_t       stats;
	report_t            pending_reports[$];
	report_t            oldest;

	image_extreme_pixel_stats DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.report_valid (report_valid),
		.report_ready (report_ready),
		.report       (report)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		report_ready <= ($urandom_range(99) >= idle_pct);
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			flag_mismatch($sformatf("kind %0d %s got %0d want %0d", oldest.report_kind,
				name, got, want));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && report_valid && report_ready) begin
			if (pending_reports.size() == 0) begin
				flag_mismatch("report beat with no report expected");
			end else begin
				oldest = pending_reports.pop_front();
				check_field("report_kind", report.report_kind, oldest.report_kind);
				check_field("pos_x", report.pos_x, oldest.pos_x);
				check_field("pos_y", report.pos_y, oldest.pos_y);
				check_field("pix_red", report.pix_red, oldest.pix_red);
				check_field("pix_green", report.pix_green, oldest.pix_green);
				check_field("pix_blue", report.pix_blue, oldest.pix_blue);
				check_field("extreme_value", report.extreme_value, oldest.extreme_value);
				check_field("last_report", report.last_report, oldest.last_report);
			end
		end
	end

	always @(posedge clk) begin
		if ((pixel_valid && pixel_ready) || (report_valid && report_ready)
				|| (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic clear_frame();
		column_now = '0;
		row_now    = '0;
		frame_open = 1'b0;
		stats      = '0;
	endtask

	// fold one accepted pixel into the trackers, queue reports on end of frame
	task automatic tally_pixel(input pixel_t p);
		logic [CHAN_W-1:0] ch [CHANNELS];
		logic [SUM_W-1:0]  sum;
		logic [POS_W-1:0]  here;
		int unsigned       wrap;
		report_t           r;
		ch[0] = p.red;
		ch[1] = p.green;
		ch[2] = p.blue;
		sum   = SUM_W'(ch[0]) + SUM_W'(ch[1]) + SUM_W'(ch[2]);
		here  = {row_now, column_now};
		if (!frame_open || sum > stats.sum_val[SLOT_MAX]) begin
			stats.sum_val[SLOT_MAX]  = sum;
			stats.sum_col[SLOT_MAX]  = {ch[2], ch[1], ch[0]};
			stats.pos[KIND_MAX_PIX]  = here;
		end
		if (!frame_open || sum < stats.sum_val[SLOT_MIN]) begin
			stats.sum_val[SLOT_MIN]  = sum;
			stats.sum_col[SLOT_MIN]  = {ch[2], ch[1], ch[0]};
			stats.pos[KIND_MIN_PIX]  = here;
		end
		for (int k = 0; k < CHANNELS; k++) begin
			if (!frame_open || ch[k] > stats.chan_val[k]) begin
				stats.chan_val[k]          = ch[k];
				stats.pos[KIND_MAX_R + k]  = here;
			end
			if (!frame_open || ch[k] < stats.chan_val[CHANNELS + k]) begin
				stats.chan_val[CHANNELS + k]          = ch[k];
				stats.pos[KIND_MAX_R + CHANNELS + k]  = here;
			end
		end
		frame_open = 1'b1;

		// zero width acts as one, anything past the widest row clamps
		if (image_width == '0) begin
			wrap = 1;
		end else if (image_width > MAX_WIDTH) begin
			wrap = MAX_WIDTH;
		end else begin
			wrap = image_width;
		end
		if (32'(column_now) + 1 >= wrap) begin
			column_now = '0;
			if (row_now < ROW_LAST) begin
				row_now = row_now + 1'b1;
			end
		end else begin
			column_now = column_now + 1'b1;
		end

		if (p.end_of_frame) begin
			for (int k = 0; k < KIND_COUNT; k++) begin
				r             = '0;
				r.report_kind = 3'(k);
				r.pos_x       = stats.pos[k][COORD_W-1:0];
				r.pos_y       = stats.pos[k][POS_W-1:COORD_W];
				if (k < KIND_MAX_R) begin
					{r.pix_blue, r.pix_green, r.pix_red} = stats.sum_col[k];
					r.extreme_value = stats.sum_val[k];
				end else begin
					r.extreme_value = SUM_W'(stats.chan_val[k - KIND_MAX_R]);
				end
				r.last_report = (k == KIND_MIN_B);
				pending_reports.push_back(r);
			end
			clear_frame();
		end
	endtask

	task automatic send_pixel(input pixel_t p);
		while ($urandom_range(99) < idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel       <= p;
		@(posedge clk);
		while (!pixel_ready) begin
			@(posedge clk);
		end
		tally_pixel(p);
	endtask

	// hold the pixel side until every queued report is out and the block settles
	task automatic await_reports();
		pixel_valid <= 1'b0;
		while (pending_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(input logic [WIDTH_W-1:0] w);
		await_reports();
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid   <= 1'b0;
		image_width = w;
	endtask

	function automatic pixel_t pixel_of(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
			input logic [CHAN_W-1:0] b, input logic eof);
		pixel_t p;
		p.red          = r;
		p.green        = g;
		p.blue         = b;
		p.end_of_frame = eof;
		return p;
	endfunction

	function automatic pixel_t random_pixel(input logic eof);
		pixel_t p;
		p = pixel_of(8'($urandom), 8'($urandom), 8'($urandom), eof);
		case ($urandom_range(3))
			0: begin
				p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
				p.green = $urandom_range(1) ? 8'hFF : 8'h00;
				p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			// a narrow band so equal sums and channels are common
			1: begin
				p.red   = 8'($urandom_range(122, 120));
				p.green = 8'($urandom_range(122, 120));
				p.blue  = 8'($urandom_range(122, 120));
			end
			default: begin
			end
		endcase
		return p;
	endfunction

	function automatic logic [WIDTH_W-1:0] random_width();
		case ($urandom_range(9))
			0: return '0;
			1: return MAX_WIDTH;
			2: return '1;
			3: return WIDTH_W'($urandom);
			default: return WIDTH_W'($urandom_range(12, 1));
		endcase
	endfunction

	task automatic test_single_pixel_frames();
		idle_pct = 0;
		send_pixel(pixel_of(8'hFF, 8'hFF, 8'hFF, 1'b1));
		send_pixel(pixel_of(8'h00, 8'h00, 8'h00, 1'b1));
		for (int i = 0; i < 4; i++) begin
			send_pixel(random_pixel(1'b1));
		end
		idle_pct = 24;
	endtask

	task automatic test_ties_and_extremes();
		send_pixel(pixel_of(8'd10, 8'd20, 8'd30, 1'b0));
		send_pixel(pixel_of(8'd30, 8'd20, 8'd10, 1'b0));
		send_pixel(pixel_of(8'hFF, 8'h00, 8'h00, 1'b0));
		send_pixel(pixel_of(8'h00, 8'hFF, 8'h00, 1'b0));
		send_pixel(pixel_of(8'h00, 8'h00, 8'hFF, 1'b0));
		send_pixel(pixel_of(8'h00, 8'h00, 8'h00, 1'b0));
		send_pixel(pixel_of(8'hFF, 8'hFF, 8'hFF, 1'b0));
		send_pixel(pixel_of(8'hFF, 8'hFF, 8'hFF, 1'b0));
		send_pixel(pixel_of(8'h00, 8'h00, 8'h00, 1'b1));
	endtask

	task automatic test_narrow_widths();
		write_width('0);
		for (int i = 0; i < 4; i++) begin
			send_pixel(random_pixel(i == 3));
		end
		write_width(WIDTH_W'(1));
		for (int i = 0; i < 3; i++) begin
			send_pixel(random_pixel(i == 2));
		end
		write_width(WIDTH_W'(3));
		for (int i = 0; i < 7; i++) begin
			send_pixel(random_pixel(i == 6));
		end
	endtask

	task automatic test_width_change_in_frame();
		write_width(WIDTH_W'(8));
		for (int i = 0; i < 6; i++) begin
			send_pixel(random_pixel(1'b0));
		end
		// column is already past the new width and wraps after the next beat
		write_width(WIDTH_W'(3));
		for (int i = 0; i < 3; i++) begin
			send_pixel(random_pixel(1'b0));
		end
		write_width(MAX_WIDTH);
		send_pixel(random_pixel(1'b0));
		send_pixel(random_pixel(1'b1));
	endtask

	task automatic test_random_frames();
		int unsigned sent     = 0;
		int unsigned frame_no = 0;
		int unsigned len;
		while (sent < RANDOM_PIXELS) begin
			// a run of frames with no gaps on either side
			idle_pct = (frame_no >= 8 && frame_no < 16) ? 0 : 24;
			if ($urandom_range(3) == 0) begin
				write_width(random_width());
			end else if ($urandom_range(9) == 0) begin
				await_reports();
			end
			len = ($urandom_range(7) == 0) ? $urandom_range(80, 25) : $urandom_range(24, 1);
			for (int i = 1; i <= len; i++) begin
				if (i == len / 2 && $urandom_range(9) == 0) begin
					write_width(random_width());
				end
				send_pixel(random_pixel(i == len));
			end
			sent += len;
			frame_no++;
		end
		idle_pct = 24;
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		pixel_valid  = 1'b0;
		pixel        = '0;
		report_ready = 1'b0;
		image_width  = WIDTH_RESET;
		clear_frame();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_pixel_frames();
		test_ties_and_extremes();
		test_narrow_widths();
		test_width_change_in_frame();
		test_random_frames();

		await_reports();
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/iems_pkg.sv
rtl/iems_front.sv
rtl/iems_queue.sv
rtl/iems_back.sv
rtl/image_extreme_pixel_stats.sv
tb/sv/testbench.sv
